// ----- rtl/core/srm_pkg.sv -----
// Shared types and constants for the sensor running average monitor.
// Sizing of the sensor table and sample window, status codes and the window RAM request.
// No dependencies.
`timescale 1ns / 1ps

package srm_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int AVG_LEN     = 8;

    localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int SLOT_W    = $clog2(AVG_LEN);
    localparam int FILL_W    = $clog2(AVG_LEN + 1);
    localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
    localparam int SUM_W     = 16 + $clog2(AVG_LEN) + 1;
    localparam int WIN_DEPTH = MAX_SENSORS * AVG_LEN;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd1;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_READING  = 1'b1;

    localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd6400;
    localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd3840;

    typedef enum logic [1:0] {
        STATUS_READING    = 2'd0,
        STATUS_UNKNOWN    = 2'd1,
        STATUS_REGISTERED = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [WIN_AW-1:0]  addr;
        logic signed [15:0] wdata;
    } win_req_t;

endpackage

// ----- rtl/core/srm_window_ram.sv -----
// Sample window memory: one ring of readings per sensor entry.
// Single port, read-before-write, registered read data. Uses srm_pkg.
`timescale 1ns / 1ps

module srm_window_ram (
    input  logic                aclk,
    input  srm_pkg::win_req_t   req,
    output logic signed [15:0]  rd_data
);

    logic signed [15:0] mem [srm_pkg::WIN_DEPTH];
    logic signed [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sensor_running_average_monitor_core.sv -----
// Top level of the sensor running average monitor: sensor table, window sums, thresholds.
// Depends on srm_pkg and srm_window_ram.
`timescale 1ns / 1ps

// Usage
//   Input channel (s_*): one transaction per item. kind 0 registers the sensor key in
//   room_id, kind 1 delivers a reading (value, timestamp) for that sensor.
//   Result channel (m_*): exactly one transaction per input item, in input order, giving
//   status, room, windowed average with its valid flag, the two threshold flags, the
//   timestamp of the reading and the number of registered sensors.
//   Configuration: cfg_wr_en with cfg_index 0 writes max_temp, 1 writes min_temp; other
//   indexes are ignored. Write only while no transaction is in flight.
// Timing
//   Results pass the input register, table lookup with window RAM read, and sum
//   update and compare into the result register. Throughput is one transaction per
//   cycle unless m_ready stalls the pipeline; the single-port window RAM is read and
//   written once per reading, and the running sum is updated incrementally.
// Reset
//   aresetn (synchronous) empties the pipeline and the sensor table and restores the
//   thresholds. No clearing pass is needed; the block is ready in the first cycle after.
// Back-pressure
//   While m_valid is high and m_ready low the whole pipeline holds and s_ready drops.

module sensor_running_average_monitor_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [srm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [15:0]                         s_sensor_key,
    input  logic [15:0]                         s_room_id,
    input  logic signed [15:0]                  s_value,
    input  logic [31:0]                         s_timestamp,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [15:0]                         m_room,
    output logic signed [15:0]                  m_average,
    output logic                                m_average_valid,
    output logic                                m_too_hot,
    output logic                                m_too_cold,
    output logic [31:0]                         m_last_update,
    output logic [4:0]                          m_sensor_count
);

    localparam int N = srm_pkg::MAX_SENSORS;
    localparam logic signed [srm_pkg::SUM_W-1:0] AVG_DIV = srm_pkg::SUM_W'(srm_pkg::AVG_LEN);

    typedef struct packed {
        srm_pkg::status_t           status;
        logic [srm_pkg::IDX_W-1:0]  idx;
        logic [15:0]                room;
        logic                       old_valid;
        logic                       full;
        logic signed [15:0]         value;
        logic [31:0]                ts;
        logic [srm_pkg::CNT_W-1:0]  count;
    } s2_t;

    logic                               advance;

    logic signed [15:0]                 max_temp_reg;
    logic signed [15:0]                 min_temp_reg;

    logic                               s1_valid_reg;
    logic                               s1_kind_reg;
    logic [15:0]                        s1_id_reg;
    logic [15:0]                        s1_room_reg;
    logic signed [15:0]                 s1_value_reg;
    logic [31:0]                        s1_ts_reg;

    logic [N-1:0]                       entry_used_reg;
    logic [15:0]                        entry_id_reg   [N];
    logic [15:0]                        entry_room_reg [N];
    logic [srm_pkg::SLOT_W-1:0]         slot_reg       [N];
    logic [srm_pkg::FILL_W-1:0]         fill_reg       [N];
    logic signed [srm_pkg::SUM_W-1:0]   sum_reg        [N];
    logic [srm_pkg::CNT_W-1:0]          used_count_reg;
    logic [srm_pkg::CNT_W-1:0]          used_count_next;

    logic                               hit;
    logic [srm_pkg::IDX_W-1:0]          hit_idx;
    logic                               free;
    logic [srm_pkg::IDX_W-1:0]          free_idx;
    logic [srm_pkg::IDX_W-1:0]          tgt_idx;
    logic                               do_register;
    logic                               do_reading;
    logic [srm_pkg::SLOT_W-1:0]         slot_cur;
    logic [srm_pkg::FILL_W-1:0]         fill_cur;
    logic [srm_pkg::SLOT_W-1:0]         slot_next;
    logic [srm_pkg::FILL_W-1:0]         fill_next;
    s2_t                                s2_next;

    srm_pkg::win_req_t                  win_req;
    logic signed [15:0]                 win_rd_data;

    logic                               s2_valid_reg;
    s2_t                                s2_reg;

    logic signed [srm_pkg::SUM_W-1:0]   sum_cur;
    logic signed [srm_pkg::SUM_W-1:0]   old_ext;
    logic signed [srm_pkg::SUM_W-1:0]   sum_new;
    logic signed [srm_pkg::SUM_W-1:0]   avg_wide;
    logic signed [15:0]                 avg;
    logic                               s2_reading;

    logic                               m_valid_reg;
    logic [1:0]                         m_status_reg;
    logic [15:0]                        m_room_reg;
    logic signed [15:0]                 m_average_reg;
    logic                               m_average_valid_reg;
    logic                               m_too_hot_reg;
    logic                               m_too_cold_reg;
    logic [31:0]                        m_last_update_reg;
    logic [4:0]                         m_sensor_count_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_temp_reg <= srm_pkg::MAX_TEMP_RESET;
            min_temp_reg <= srm_pkg::MIN_TEMP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srm_pkg::CFG_MAX_TEMP: max_temp_reg <= cfg_wdata;
                srm_pkg::CFG_MIN_TEMP: min_temp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg  <= s_kind;
            s1_id_reg    <= s_sensor_key;
            s1_room_reg  <= s_room_id;
            s1_value_reg <= s_value;
            s1_ts_reg    <= s_timestamp;
        end
    end

    // lookup: lowest matching entry, lowest free entry
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (entry_used_reg[i] && (entry_id_reg[i] == s1_id_reg)) begin
                hit     = 1'b1;
                hit_idx = srm_pkg::IDX_W'(i);
            end
            if (!entry_used_reg[i]) begin
                free     = 1'b1;
                free_idx = srm_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        slot_cur        = slot_reg[hit_idx];
        fill_cur        = fill_reg[hit_idx];
        slot_next       = (slot_cur == srm_pkg::SLOT_W'(srm_pkg::AVG_LEN - 1)) ?
                          '0 : slot_cur + 1'b1;
        fill_next       = (fill_cur == srm_pkg::FILL_W'(srm_pkg::AVG_LEN)) ?
                          fill_cur : fill_cur + 1'b1;
        tgt_idx         = hit ? hit_idx : free_idx;
        do_register     = s1_valid_reg && (s1_kind_reg == srm_pkg::KIND_REGISTER) &&
                          (hit || free);
        do_reading      = s1_valid_reg && (s1_kind_reg == srm_pkg::KIND_READING) && hit;
        used_count_next = used_count_reg;
        if (do_register && !hit) begin
            used_count_next = used_count_reg + 1'b1;
        end

        s2_next           = '0;
        s2_next.idx       = hit_idx;
        s2_next.value     = s1_value_reg;
        s2_next.ts        = s1_ts_reg;
        s2_next.count     = used_count_next;
        s2_next.old_valid = (fill_cur == srm_pkg::FILL_W'(srm_pkg::AVG_LEN));
        s2_next.full      = (fill_next == srm_pkg::FILL_W'(srm_pkg::AVG_LEN));
        if (s1_kind_reg == srm_pkg::KIND_REGISTER) begin
            if (hit || free) begin
                s2_next.status = srm_pkg::STATUS_REGISTERED;
                s2_next.room   = s1_room_reg;
            end else begin
                s2_next.status = srm_pkg::STATUS_FULL;
            end
        end else if (hit) begin
            s2_next.status = srm_pkg::STATUS_READING;
            s2_next.room   = entry_room_reg[hit_idx];
        end else begin
            s2_next.status = srm_pkg::STATUS_UNKNOWN;
        end

        win_req.rd_en = advance;
        win_req.wr_en = advance && do_reading;
        win_req.addr  = srm_pkg::WIN_AW'(hit_idx) * srm_pkg::WIN_AW'(srm_pkg::AVG_LEN) +
                        srm_pkg::WIN_AW'(slot_cur);
        win_req.wdata = s1_value_reg;
    end

    srm_window_ram u_window_ram (
        .aclk    (aclk),
        .req     (win_req),
        .rd_data (win_rd_data)
    );

    // sensor table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_used_reg <= '0;
            used_count_reg <= '0;
        end else if (advance) begin
            used_count_reg <= used_count_next;
            if (do_register) begin
                entry_used_reg[tgt_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s2_valid_reg && s2_reading &&
                    !(do_register && (tgt_idx == s2_reg.idx))) begin
                sum_reg[s2_reg.idx] <= sum_new;
            end
            if (do_register) begin
                entry_id_reg[tgt_idx]   <= s1_id_reg;
                entry_room_reg[tgt_idx] <= s1_room_reg;
                slot_reg[tgt_idx]       <= '0;
                fill_reg[tgt_idx]       <= '0;
                sum_reg[tgt_idx]        <= '0;
            end
            if (do_reading) begin
                slot_reg[hit_idx] <= slot_next;
                fill_reg[hit_idx] <= fill_next;
            end
        end
    end

    // second stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_reg <= s2_next;
        end
    end

    always_comb begin
        s2_reading = (s2_reg.status == srm_pkg::STATUS_READING);
        sum_cur    = sum_reg[s2_reg.idx];
        old_ext    = s2_reg.old_valid ?
                     {{(srm_pkg::SUM_W-16){win_rd_data[15]}}, win_rd_data} : '0;
        sum_new    = sum_cur - old_ext +
                     {{(srm_pkg::SUM_W-16){s2_reg.value[15]}}, s2_reg.value};
        avg_wide   = sum_new / AVG_DIV;
        avg        = avg_wide[15:0];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg       <= s2_reg.status;
            m_room_reg         <= s2_reg.room;
            m_sensor_count_reg <= 5'(s2_reg.count);
            if (s2_reading) begin
                m_last_update_reg <= s2_reg.ts;
            end else begin
                m_last_update_reg <= '0;
            end
            if (s2_reading && s2_reg.full) begin
                m_average_reg       <= avg;
                m_average_valid_reg <= 1'b1;
                m_too_hot_reg       <= (avg > max_temp_reg);
                m_too_cold_reg      <= (avg < min_temp_reg);
            end else begin
                m_average_reg       <= '0;
                m_average_valid_reg <= 1'b0;
                m_too_hot_reg       <= 1'b0;
                m_too_cold_reg      <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_room          = m_room_reg;
    assign m_average       = m_average_reg;
    assign m_average_valid = m_average_valid_reg;
    assign m_too_hot       = m_too_hot_reg;
    assign m_too_cold      = m_too_cold_reg;
    assign m_last_update   = m_last_update_reg;
    assign m_sensor_count  = m_sensor_count_reg;

`ifndef SYNTH
    a_count_matches_table: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(entry_used_reg) == 32'(used_count_reg))
        else $error("sensor count disagrees with table occupancy");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_count_reg) <= N)
        else $error("sensor count exceeds table size");

    a_partial_window_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_average_valid_reg |->
            m_average_reg == 16'sd0 && !m_too_hot_reg && !m_too_cold_reg)
        else $error("average or flags set without a full window");

    a_non_reading_no_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != srm_pkg::STATUS_READING) |->
            m_last_update_reg == 32'd0 && !m_average_valid_reg)
        else $error("timestamp or average reported for a non-reading transaction");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for sensor_running_average_monitor_core: sensor table, window
// averages and threshold flags, checked against a scoreboard with its own table model.
// Depends on srm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import srm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 225;
    localparam int PHASES      = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        status_t            status;
        logic [15:0]        room;
        logic signed [15:0] average;
        logic               average_valid;
        logic               too_hot;
        logic               too_cold;
        logic [31:0]        last_update;
        logic [4:0]         sensor_count;
    } monitor_result_t;

    class monitor_scoreboard;
        logic signed [15:0] hot_limit;
        logic signed [15:0] cold_limit;
        bit                 used [MAX_SENSORS];
        logic [15:0]        ids [MAX_SENSORS];
        logic [15:0]        rooms [MAX_SENSORS];
        logic signed [15:0] ring [MAX_SENSORS][AVG_LEN];
        int                 slot [MAX_SENSORS];
        int                 fill [MAX_SENSORS];
        int                 sum [MAX_SENSORS];
        logic [31:0]        stamp [MAX_SENSORS];
        int                 count;
        int                 mismatches;
        monitor_result_t    expected_results [$];

        function new();
            hot_limit  = MAX_TEMP_RESET;
            cold_limit = MIN_TEMP_RESET;
            count      = 0;
            mismatches = 0;
            for (int i = 0; i < MAX_SENSORS; i++) begin
                used[i]  = 1'b0;
                ids[i]   = '0;
                rooms[i] = '0;
                clear_entry(i);
            end
        endfunction

        function void clear_entry(int e);
            for (int k = 0; k < AVG_LEN; k++)
                ring[e][k] = '0;
            slot[e]  = 0;
            fill[e]  = 0;
            sum[e]   = 0;
            stamp[e] = '0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MAX_TEMP: hot_limit = data;
                CFG_MIN_TEMP: cold_limit = data;
                default: ;
            endcase
        endfunction

        function int lookup(logic [15:0] id);
            for (int i = 0; i < MAX_SENSORS; i++)
                if (used[i] && ids[i] == id)
                    return i;
            return -1;
        endfunction

        function void note_item(logic kind, logic [15:0] id, logic [15:0] room,
                                logic signed [15:0] value, logic [31:0] stamp_in);
            monitor_result_t r;
            int e;
            int avg;
            r.status        = STATUS_UNKNOWN;
            r.room          = '0;
            r.average       = '0;
            r.average_valid = 1'b0;
            r.too_hot       = 1'b0;
            r.too_cold      = 1'b0;
            r.last_update   = '0;
            e = lookup(id);
            if (kind == KIND_REGISTER) begin
                if (e < 0) begin
                    for (int i = MAX_SENSORS - 1; i >= 0; i--)
                        if (!used[i])
                            e = i;
                    if (e >= 0) begin
                        used[e] = 1'b1;
                        ids[e]  = id;
                        count++;
                    end
                end
                if (e < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    rooms[e] = room;
                    clear_entry(e);
                    r.status = STATUS_REGISTERED;
                    r.room   = room;
                end
            end else if (e >= 0) begin
                sum[e] = sum[e] - ring[e][slot[e]] + value;
                ring[e][slot[e]] = value;
                slot[e] = (slot[e] + 1) % AVG_LEN;
                if (fill[e] < AVG_LEN)
                    fill[e]++;
                stamp[e] = stamp_in;
                if (fill[e] >= AVG_LEN) begin
                    avg             = sum[e] / AVG_LEN;
                    r.average       = 16'(avg);
                    r.average_valid = 1'b1;
                    r.too_hot       = avg > hot_limit;
                    r.too_cold      = avg < cold_limit;
                end
                r.status      = STATUS_READING;
                r.room        = rooms[e];
                r.last_update = stamp_in;
            end
            r.sensor_count = 5'(count);
            expected_results.push_back(r);
        endfunction

        function void check_result(monitor_result_t got);
            monitor_result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d room %h", got.status, got.room);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.room !== want.room
                    || got.average !== want.average
                    || got.average_valid !== want.average_valid
                    || got.too_hot !== want.too_hot || got.too_cold !== want.too_cold
                    || got.last_update !== want.last_update
                    || got.sensor_count !== want.sensor_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: st %0d room %h avg %0d v %b hot %b cold %b ts %h n %0d",
                             want.status, want.room, want.average, want.average_valid,
                             want.too_hot, want.too_cold, want.last_update, want.sensor_count);
                    $display("         got: st %0d room %h avg %0d v %b hot %b cold %b ts %h n %0d",
                             got.status, got.room, got.average, got.average_valid,
                             got.too_hot, got.too_cold, got.last_update, got.sensor_count);
                end
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [15:0]            cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_kind;
    logic [15:0]            s_sensor_key;
    logic [15:0]            s_room_id;
    logic signed [15:0]     s_value;
    logic [31:0]            s_timestamp;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_status;
    logic [15:0]            m_room;
    logic signed [15:0]     m_average;
    logic                   m_average_valid;
    logic                   m_too_hot;
    logic                   m_too_cold;
    logic [31:0]            m_last_update;
    logic [4:0]             m_sensor_count;

    monitor_scoreboard sb;
    logic [15:0]       pool [POOL_SIZE];
    bit                steady = 1'b0;
    int                results_seen = 0;
    int                cycles = 0;

    sensor_running_average_monitor_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_sensor_key    (s_sensor_key),
        .s_room_id       (s_room_id),
        .s_value         (s_value),
        .s_timestamp     (s_timestamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_room          (m_room),
        .m_average       (m_average),
        .m_average_valid (m_average_valid),
        .m_too_hot       (m_too_hot),
        .m_too_cold      (m_too_cold),
        .m_last_update   (m_last_update),
        .m_sensor_count  (m_sensor_count)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        monitor_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status        = status_t'(m_status);
            got.room          = m_room;
            got.average       = m_average;
            got.average_valid = m_average_valid;
            got.too_hot       = m_too_hot;
            got.too_cold      = m_too_cold;
            got.last_update   = m_last_update;
            got.sensor_count  = m_sensor_count;
            sb.check_result(got);
            results_seen++;
        end
    end

    // result side: random stalls, one long hold-off to back the pipeline up
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (!held && results_seen >= 120) begin
                held      = 1'b1;
                hold_left = 300;
                m_ready   = 1'b0;
            end else begin
                m_ready = steady || ($urandom_range(99, 0) >= 34);
            end
        end
    end

    task automatic send_item(logic kind, logic [15:0] id, logic [15:0] room,
                             logic signed [15:0] value, logic [31:0] stamp);
        while (!steady && $urandom_range(99, 0) < 34)
            @(negedge aclk);
        s_valid      = 1'b1;
        s_kind       = kind;
        s_sensor_key = id;
        s_room_id    = room;
        s_value      = value;
        s_timestamp  = stamp;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_item(kind, id, room, value, stamp);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.set_threshold(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.expected_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(3, 0))
            0: return 16'($urandom);
            1: return 16'($urandom_range(10240, 1280));
            2: return 16'(-int'($urandom_range(2560, 0)));
            default: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic logic [15:0] pick_reading_id();
        if ($urandom_range(9, 0) == 0)
            return 16'($urandom);
        return pool[$urandom_range(POOL_SIZE - 1, 0)];
    endfunction

    task automatic send_batch(output int sent);
        logic [15:0]        id;
        logic signed [15:0] base;
        int                 len;
        if ($urandom_range(1, 0) == 1) begin
            id   = pool[$urandom_range(POOL_SIZE - 1, 0)];
            len  = $urandom_range(20, 1);
            base = 16'($urandom_range(9000, 2000));
            for (int k = 0; k < len; k++)
                send_item(KIND_READING, id, 16'($urandom),
                          base + 16'($urandom_range(600, 0)) - 16'sd300, $urandom);
            sent = len;
        end else begin
            if ($urandom_range(99, 0) < 4) begin
                id = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                 : pool[$urandom_range(POOL_SIZE - 1, 0)];
                send_item(KIND_REGISTER, id, 16'($urandom), pick_value(), $urandom);
            end else begin
                send_item(KIND_READING, pick_reading_id(), 16'($urandom), pick_value(),
                          $urandom);
            end
            sent = 1;
        end
    endtask

    initial begin
        int          sent;
        int          done;
        int          j;
        bit          clash;
        logic [15:0] swap;

        sb           = new();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_MAX_TEMP;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_kind       = KIND_REGISTER;
        s_sensor_key = '0;
        s_room_id    = '0;
        s_value      = '0;
        s_timestamp  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: unknown id on an empty table, extreme ids, rooms, values and stamps
        send_item(KIND_READING, 16'h1234, 16'h5555, 16'sd100, 32'h0000_0001);
        send_item(KIND_REGISTER, 16'h0000, 16'h0000, 16'sh7fff, 32'hffff_ffff);
        send_item(KIND_REGISTER, 16'hffff, 16'hffff, 16'sh8000, 32'h0000_0000);
        for (int k = 0; k < AVG_LEN; k++)
            send_item(KIND_READING, 16'hffff, 16'h0000, 16'sh7fff, 32'hffff_fff8 + k);
        for (int k = 0; k < AVG_LEN; k++)
            send_item(KIND_READING, 16'h0000, 16'hffff, 16'sh8000, k);
        // re-register: same slot, new room, history dropped
        send_item(KIND_REGISTER, 16'hffff, 16'h00aa, 16'sd0, 32'h1234_5678);
        send_item(KIND_READING, 16'hffff, 16'h0000, 16'sd0, 32'h0000_0100);
        send_item(KIND_READING, 16'hbeef, 16'h0000, 16'sd0, 32'h0000_0200);

        pool[0] = 16'h0000;
        pool[1] = 16'hffff;
        for (int i = 2; i < POOL_SIZE; i++) begin
            do begin
                pool[i] = 16'($urandom_range(65534, 1));
                clash   = 1'b0;
                for (int k = 0; k < i; k++)
                    if (pool[k] == pool[i])
                        clash = 1'b1;
            end while (clash);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            case (phase)
                1: begin
                    write_threshold(CFG_MAX_TEMP, 16'h7fff);
                    write_threshold(CFG_MIN_TEMP, 16'h8000);
                end
                2: begin
                    write_threshold(CFG_MAX_TEMP, 16'h8000);
                    write_threshold(CFG_MIN_TEMP, 16'h7fff);
                    steady = 1'b1;
                end
                3: begin
                    steady = 1'b0;
                    write_threshold(CFG_MAX_TEMP, 16'($urandom_range(9000, 4000)));
                    write_threshold(CFG_MIN_TEMP, 16'($urandom_range(6000, 1000)));
                    write_threshold(CFG_SPARE, 16'($urandom));
                end
                4: begin
                    write_threshold(CFG_MAX_TEMP, 16'h0000);
                    write_threshold(CFG_MIN_TEMP, 16'h0000);
                end
                default: ;
            endcase
            if (phase == 0) begin
                // fill the table in random order; the last few find it full
                for (int i = POOL_SIZE - 1; i > 0; i--) begin
                    j       = $urandom_range(i, 0);
                    swap    = pool[i];
                    pool[i] = pool[j];
                    pool[j] = swap;
                end
                for (int i = 0; i < POOL_SIZE; i++)
                    send_item(KIND_REGISTER, pool[i], 16'($urandom), pick_value(), $urandom);
            end
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_batch(sent);
                done += sent;
            end
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/srm_pkg.sv
rtl/core/srm_window_ram.sv
rtl/core/sensor_running_average_monitor_core.sv
tb/tb.sv
